### hw/rtl/legendre_symbol_binary_gcd_defines.svh
// Assertion helpers for the RTL that carries checks (only lsbg_ctrl includes them).
// Both sample on clock and are off while reset is high.
`ifndef LEGENDRE_SYMBOL_BINARY_GCD_DEFINES_SVH
`define LEGENDRE_SYMBOL_BINARY_GCD_DEFINES_SVH

// Same-cycle implication.
`define LSBG_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define LSBG_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### hw/rtl/lsbg_pkg.sv
`default_nettype none
package lsbg_pkg;

   localparam logic [255:0] MODULUS =
      256'h62d7f37f9815e5fc_a7ecc14ec3fa83c7_ffffffffffffffff_ffffffffffffffff;
   localparam logic [63:0] BIAS    = 64'h7FFFFFFF7FFFFFFF;
   localparam logic [32:0] LOW31   = 33'h07FFFFFFF;
   localparam logic [63:0] FB_INIT = 64'h0000000100000000;

   // last index of each counted phase
   localparam logic [5:0] STEP_LAST   = 6'd28;
   localparam logic [5:0] PMAC_LAST   = 6'd7;
   localparam logic [5:0] PSTEP_LAST  = 6'd1;
   localparam logic [5:0] CMAC_LAST   = 6'd15;
   localparam logic [5:0] FINAL_LAST  = 6'd34;
   localparam logic [3:0] ROUND_LAST  = 4'd14;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WIN_A,
      ST_WIN_B,
      ST_STEP,
      ST_PMAC,
      ST_PSTEP,
      ST_CMAC,
      ST_CSTORE,
      ST_FLOAD,
      ST_FSTEP,
      ST_DONE
   } lsbg_state_type;

   typedef struct packed {
      logic       load;
      logic       win_a;
      logic       win_b;
      logic       step;
      logic       step_p;
      logic       mac;
      logic       mac_clear;
      logic       mac_v;
      logic [2:0] mac_k;
      logic       mac_sel;
      logic       store_pa;
      logic       store_pb;
      logic       store_nu;
      logic       store_nv;
      logic       final_load;
   } lsbg_cmd_type;

   typedef struct packed {
      logic is_square;
   } lsbg_status_type;

endpackage
`default_nettype wire

### hw/rtl/lsbg_datapath.sv
`default_nettype none
module lsbg_datapath (
   input  wire logic                      clock,
   input  wire lsbg_pkg::lsbg_cmd_type    cmd,
   input  wire logic [63:0]               value_limb0,
   input  wire logic [63:0]               value_limb1,
   input  wire logic [63:0]               value_limb2,
   input  wire logic [63:0]               value_limb3,
   output lsbg_pkg::lsbg_status_type      status
);
   import lsbg_pkg::*;

   logic [255:0] u_ff, u_in, v_ff, v_in, nu_ff, nu_in, w_ff, w_in;
   logic [63:0]  tm_ff, tm_in, tu_ff, tu_in, tv_ff, tv_in, su_ff, su_in, sv_ff, sv_in;
   logic         none_ff, none_in;
   logic [63:0]  wa_ff, wa_in, wb_ff, wb_in, fa_ff, fa_in, fb_ff, fb_in;
   logic [63:0]  pa_ff, pa_in, pb_ff, pb_in;
   logic [67:0]  mac_ff, mac_in;
   logic         acc_ff, acc_in, neg_ff, neg_in, zero_ff, zero_in;

   logic [63:0]  h3, h2, h1;
   logic         n3, n2, n1;
   logic [6:0]   sh, sh_m32;
   logic         big;
   logic [5:0]   sh2;
   logic [63:0]  tu1, tv1, tu2, tv2, tu3, tv3;

   logic         odd, sw, acc_flip;
   logic [63:0]  a_s, b_s, fa_s, fb_s, pa_s, pb_s;

   logic [31:0]  chunk;
   logic [63:0]  z;
   logic [32:0]  f_lo, g_hi, factor;
   logic [65:0]  product;
   logic [67:0]  base, sum;

   logic [255:0] x, r;
   logic         s;

   function automatic logic [6:0] clz64(input logic [63:0] val);
      logic [6:0] n;
      n = 7'd64;
      for (int i = 0; i < 64; i++) begin
         if (val[i]) begin
            n = 7'(63 - i);
         end
      end
      return n;
   endfunction

   always_comb begin
      // window select
      h3 = u_ff[255:192] | v_ff[255:192];
      h2 = u_ff[191:128] | v_ff[191:128];
      h1 = u_ff[127:64]  | v_ff[127:64];
      n3 = |h3;
      n2 = (|h2) & ~n3;
      n1 = (|h1) & ~n3 & ~n2;

      // window normalize
      sh     = clz64(tm_ff);
      big    = (sh > 7'd31);
      sh_m32 = sh - 7'd32;
      sh2    = big ? sh_m32[5:0] : sh[5:0];
      tu1    = big ? {tu_ff[31:0], su_ff[63:32]} : tu_ff;
      tv1    = big ? {tv_ff[31:0], sv_ff[63:32]} : tv_ff;
      tu2    = tu1 << sh2;
      tv2    = tv1 << sh2;
      tu3    = tu2 | (none_ff ? u_ff[63:0] : 64'd0);
      tv3    = tv2 | (none_ff ? v_ff[63:0] : 64'd0);

      // one halving step
      odd  = wa_ff[0];
      sw   = odd & (wa_ff < wb_ff);
      a_s  = sw ? wb_ff : wa_ff;
      b_s  = sw ? wa_ff : wb_ff;
      fa_s = sw ? fb_ff : fa_ff;
      fb_s = sw ? fa_ff : fb_ff;
      pa_s = sw ? pb_ff : pa_ff;
      pb_s = sw ? pa_ff : pb_ff;
      if (cmd.step_p) begin
         acc_flip = (sw & pa_ff[1] & pb_ff[1]) ^ pb_s[2] ^ pb_s[1];
      end else begin
         acc_flip = (sw & wa_ff[1] & wb_ff[1]) ^ b_s[2] ^ b_s[1];
      end

      // multiply-accumulate, 32-bit chunk by 33-bit signed factor
      chunk   = cmd.mac_v ? v_ff[{cmd.mac_k, 5'b00000} +: 32]
                          : u_ff[{cmd.mac_k, 5'b00000} +: 32];
      z       = cmd.mac_sel ? (fb_ff + BIAS) : (fa_ff + BIAS);
      f_lo    = {1'b0, z[31:0]}  - LOW31;
      g_hi    = {1'b0, z[63:32]} - LOW31;
      factor  = cmd.mac_v ? g_hi : f_lo;
      product = $signed({1'b0, chunk}) * $signed(factor);
      base    = cmd.mac_clear ? 68'd0 : mac_ff;
      sum     = base + {{2{product[65]}}, product};

      // scale down by 2^31 and take magnitude
      x = {mac_ff[30:0], w_ff[255:31]};
      s = mac_ff[67];
      r = (x ^ {256{s}}) + {255'd0, s};

      u_in = u_ff;   v_in = v_ff;   nu_in = nu_ff; w_in = w_ff;
      tm_in = tm_ff; tu_in = tu_ff; tv_in = tv_ff; su_in = su_ff; sv_in = sv_ff;
      none_in = none_ff;
      wa_in = wa_ff; wb_in = wb_ff; fa_in = fa_ff; fb_in = fb_ff;
      pa_in = pa_ff; pb_in = pb_ff;
      mac_in = mac_ff;
      acc_in = acc_ff; neg_in = neg_ff; zero_in = zero_ff;

      if (cmd.load) begin
         u_in    = {value_limb3, value_limb2, value_limb1, value_limb0};
         v_in    = MODULUS;
         acc_in  = 1'b0;
         zero_in = ~(|{value_limb3, value_limb2, value_limb1, value_limb0});
      end
      if (cmd.win_a) begin
         tm_in   = (h3 & {64{n3}}) | (h2 & {64{n2}}) | (h1 & {64{n1}});
         tu_in   = (u_ff[255:192] & {64{n3}}) | (u_ff[191:128] & {64{n2}})
                 | (u_ff[127:64] & {64{n1}});
         tv_in   = (v_ff[255:192] & {64{n3}}) | (v_ff[191:128] & {64{n2}})
                 | (v_ff[127:64] & {64{n1}});
         su_in   = (u_ff[191:128] & {64{n3}}) | (u_ff[127:64] & {64{n2}})
                 | (u_ff[63:0] & {64{n1}});
         sv_in   = (v_ff[191:128] & {64{n3}}) | (v_ff[127:64] & {64{n2}})
                 | (v_ff[63:0] & {64{n1}});
         none_in = ~(n1 | n2 | n3);
      end
      if (cmd.win_b) begin
         wa_in = {tu3[63:31], u_ff[30:0]};
         wb_in = {tv3[63:31], v_ff[30:0]};
         fa_in = 64'd1;
         fb_in = FB_INIT;
      end
      if (cmd.step) begin
         wa_in  = (a_s - (odd ? b_s : 64'd0)) >> 1;
         wb_in  = b_s;
         fa_in  = fa_s - (odd ? fb_s : 64'd0);
         fb_in  = fb_s << 1;
         acc_in = acc_ff ^ acc_flip;
         if (cmd.step_p) begin
            pa_in = (pa_s - (odd ? pb_s : 64'd0)) >> 1;
            pb_in = pb_s;
         end
      end
      if (cmd.mac) begin
         if (cmd.mac_v) begin
            mac_in = {{32{sum[67]}}, sum[67:32]};
            w_in   = {sum[31:0], w_ff[255:32]};
         end else begin
            mac_in = sum;
         end
      end
      if (cmd.store_pa) begin
         pa_in = {29'd0, sum[31:0], w_ff[255:253]};
      end
      if (cmd.store_pb) begin
         pb_in = {29'd0, sum[31:0], w_ff[255:253]};
      end
      if (cmd.store_nu) begin
         nu_in  = r;
         neg_in = s;
      end
      if (cmd.store_nv) begin
         u_in   = nu_ff;
         v_in   = r;
         acc_in = acc_ff ^ (neg_ff & r[1]);
      end
      if (cmd.final_load) begin
         wa_in = u_ff[63:0];
         wb_in = v_ff[63:0];
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;   v_ff <= v_in;   nu_ff <= nu_in; w_ff <= w_in;
      tm_ff <= tm_in; tu_ff <= tu_in; tv_ff <= tv_in; su_ff <= su_in; sv_ff <= sv_in;
      none_ff <= none_in;
      wa_ff <= wa_in; wb_ff <= wb_in; fa_ff <= fa_in; fb_ff <= fb_in;
      pa_ff <= pa_in; pb_ff <= pb_in;
      mac_ff <= mac_in;
      acc_ff <= acc_in; neg_ff <= neg_in; zero_ff <= zero_in;
   end

   assign status.is_square = ~acc_ff & ~zero_ff;

endmodule
`default_nettype wire

### hw/rtl/lsbg_ctrl.sv
`default_nettype none
`include "legendre_symbol_binary_gcd_defines.svh"
module lsbg_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_valid,
   output lsbg_pkg::lsbg_cmd_type      cmd
);
   import lsbg_pkg::*;

   lsbg_state_type state_ff, state_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [3:0]     round_ff, round_in;
   logic           which_ff, which_in;

   // next state and counters
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 6'd1;
      round_in = round_ff;
      which_in = which_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = 6'd0;
            if (start) begin
               state_in = ST_WIN_A;
               round_in = 4'd0;
            end
         end
         ST_WIN_A: begin
            state_in = ST_WIN_B;
         end
         ST_WIN_B: begin
            state_in = ST_STEP;
            cnt_in   = 6'd0;
         end
         ST_STEP: begin
            if (cnt_ff == STEP_LAST) begin
               state_in = ST_PMAC;
               cnt_in   = 6'd0;
            end
         end
         ST_PMAC: begin
            if (cnt_ff == PMAC_LAST) begin
               state_in = ST_PSTEP;
               cnt_in   = 6'd0;
            end
         end
         ST_PSTEP: begin
            if (cnt_ff == PSTEP_LAST) begin
               state_in = ST_CMAC;
               cnt_in   = 6'd0;
               which_in = 1'b0;
            end
         end
         ST_CMAC: begin
            if (cnt_ff == CMAC_LAST) begin
               state_in = ST_CSTORE;
            end
         end
         ST_CSTORE: begin
            cnt_in = 6'd0;
            if (!which_ff) begin
               state_in = ST_CMAC;
               which_in = 1'b1;
            end else if (round_ff == ROUND_LAST) begin
               state_in = ST_FLOAD;
            end else begin
               state_in = ST_WIN_A;
               round_in = round_ff + 4'd1;
            end
         end
         ST_FLOAD: begin
            state_in = ST_FSTEP;
            cnt_in   = 6'd0;
         end
         ST_FSTEP: begin
            if (cnt_ff == FINAL_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // command decode
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_WIN_A: begin
            cmd.win_a = 1'b1;
         end
         ST_WIN_B: begin
            cmd.win_b = 1'b1;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
         end
         ST_PMAC: begin
            cmd.mac       = 1'b1;
            cmd.mac_clear = (cnt_ff[1:0] == 2'd0);
            cmd.mac_v     = cnt_ff[0];
            cmd.mac_k     = {2'b00, cnt_ff[1]};
            cmd.mac_sel   = cnt_ff[2];
            cmd.store_pa  = (cnt_ff[2:0] == 3'd3);
            cmd.store_pb  = (cnt_ff[2:0] == 3'd7);
         end
         ST_PSTEP: begin
            cmd.step   = 1'b1;
            cmd.step_p = 1'b1;
         end
         ST_CMAC: begin
            cmd.mac       = 1'b1;
            cmd.mac_clear = (cnt_ff == 6'd0);
            cmd.mac_v     = cnt_ff[0];
            cmd.mac_k     = cnt_ff[3:1];
            cmd.mac_sel   = which_ff;
         end
         ST_CSTORE: begin
            cmd.store_nu = ~which_ff;
            cmd.store_nv = which_ff;
         end
         ST_FLOAD: begin
            cmd.final_load = 1'b1;
         end
         ST_FSTEP: begin
            cmd.step = 1'b1;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 6'd0;
         round_ff <= 4'd0;
         which_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         round_ff <= round_in;
         which_ff <= which_in;
      end
   end

   `LSBG_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `LSBG_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid && !busy)
   `LSBG_ASSERT_IMP(a_step_bound, state_ff == ST_STEP, cnt_ff <= STEP_LAST)
   `LSBG_ASSERT_IMP(a_round_bound, busy, round_ff <= ROUND_LAST)

endmodule
`default_nettype wire

### hw/rtl/legendre_symbol_binary_gcd.sv
// One shared datapath runs each transaction; the result strobe comes after
//   15 rounds (window select and load, halving steps, window products, halving steps
//   on the products, two 256-bit multiply-accumulate updates plus a store each), then
//   a final load and halving steps; busy holds off a new transaction until done.
// Reset: synchronous, active high; returns to idle, any transaction in flight is dropped.
`default_nettype none
module legendre_symbol_binary_gcd (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_value_limb0,
   input  wire logic [63:0] req_value_limb1,
   input  wire logic [63:0] req_value_limb2,
   input  wire logic [63:0] req_value_limb3,
   output logic             rsp_valid,
   output logic             rsp_is_square
);
   import lsbg_pkg::*;

   lsbg_cmd_type    cmd;
   lsbg_status_type status;

   lsbg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   lsbg_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .value_limb0 (req_value_limb0),
      .value_limb1 (req_value_limb1),
      .value_limb2 (req_value_limb2),
      .value_limb3 (req_value_limb3),
      .status      (status)
   );

   assign rsp_is_square = status.is_square;

endmodule
`default_nettype wire

### tb/legendre_symbol_binary_gcd_test.sv
`default_nettype none
module legendre_symbol_binary_gcd_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lsbg_pkg::*;

   localparam int unsigned LATENCY     = 1162;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam logic [63:0] MASK31      = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] MASK_HI33   = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] MASK32      = 64'h0000_0000_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_value_limb0 = '0;
   logic [63:0] req_value_limb1 = '0;
   logic [63:0] req_value_limb2 = '0;
   logic [63:0] req_value_limb3 = '0;
   logic        rsp_valid;
   logic        rsp_is_square;

   bit          residue_queue[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          idle_enable = 1'b1;

   legendre_symbol_binary_gcd u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value_limb0 (req_value_limb0),
      .req_value_limb1 (req_value_limb1),
      .req_value_limb2 (req_value_limb2),
      .req_value_limb3 (req_value_limb3),
      .rsp_valid       (rsp_valid),
      .rsp_is_square   (rsp_is_square)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [63:0] sub_borrow(input logic bin, input logic [63:0] x,
                                              input logic [63:0] y, output logic bout);
      logic [63:0] t;
      t = x - y;
      bout = (x < y) | (bin & (t == 64'd0));
      return t - {63'd0, bin};
   endfunction

   function automatic int unsigned lead_zeros(input logic [63:0] x);
      int unsigned n;
      n = 0;
      while (n < 64 && !x[63 - n]) n++;
      return n;
   endfunction

   // |(u*f + v*g) / 2^31| into r; returns all ones when the quotient was negative
   function automatic logic [63:0] scaled_combine(output logic [3:0][63:0] r,
                                                  input logic [3:0][63:0] u,
                                                  input logic [3:0][63:0] v,
                                                  input logic [63:0] f,
                                                  input logic [63:0] g);
      logic [63:0]  sf, sg, c, s, ue4, ve4, w4;
      logic [3:0][63:0] ue, ve, w;
      logic [127:0] p;
      logic         bb, nb;
      sf = {64{f[63]}};
      sg = {64{g[63]}};
      f = (f ^ sf) - sf;
      g = (g ^ sg) - sg;
      bb = 1'b0;
      for (int i = 0; i < 4; i++) begin
         ue[i] = sub_borrow(bb, u[i] ^ sf, sf, nb);
         bb = nb;
      end
      ue4 = 64'd0 - {63'd0, bb};
      bb = 1'b0;
      for (int i = 0; i < 4; i++) begin
         ve[i] = sub_borrow(bb, v[i] ^ sg, sg, nb);
         bb = nb;
      end
      ve4 = 64'd0 - {63'd0, bb};
      c = 64'd0;
      for (int i = 0; i < 4; i++) begin
         p = {64'd0, ue[i]} * {64'd0, f} + {64'd0, ve[i]} * {64'd0, g} + {64'd0, c};
         w[i] = p[63:0];
         c = p[127:64];
      end
      w4 = c - (ue4 & f) - (ve4 & g);
      for (int i = 0; i < 3; i++) w[i] = (w[i] >> 31) | (w[i + 1] << 33);
      w[3] = (w[3] >> 31) | (w4 << 33);
      s = {64{w4[63]}};
      bb = 1'b0;
      for (int i = 0; i < 4; i++) begin
         r[i] = sub_borrow(bb, w[i] ^ s, s, nb);
         bb = nb;
      end
      return s;
   endfunction

   function automatic bit predict_residue(input logic [3:0][63:0] value);
      logic [3:0][63:0] u, v, nu, nv;
      logic [63:0] acc, wa, wb, f0, g0, f1, g1, fa, fb, pa, pb, za, zb;
      logic [63:0] h1, h2, h3, n1, n2, n3, tm, tu, tv, su, sv, big, none;
      logic [63:0] odd, sw, t, neg, ignored;
      int unsigned sh;
      u = value;
      v = MODULUS;
      acc = 64'd0;
      for (int r = 0; r < 15; r++) begin
         h3 = u[3] | v[3];
         h2 = u[2] | v[2];
         h1 = u[1] | v[1];
         n3 = {64{h3 != 64'd0}};
         n2 = {64{h2 != 64'd0}} & ~n3;
         n1 = {64{h1 != 64'd0}} & ~n3 & ~n2;
         tm = (h3 & n3) | (h2 & n2) | (h1 & n1);
         tu = (u[3] & n3) | (u[2] & n2) | (u[1] & n1);
         tv = (v[3] & n3) | (v[2] & n2) | (v[1] & n1);
         su = (u[2] & n3) | (u[1] & n2) | (u[0] & n1);
         sv = (v[2] & n3) | (v[1] & n2) | (v[0] & n1);
         sh = lead_zeros(tm);
         big = (sh > 31) ? '1 : '0;
         tu ^= big & (tu ^ ((tu << 32) | (su >> 32)));
         tv ^= big & (tv ^ ((tv << 32) | (sv >> 32)));
         if (sh > 31) sh -= 32;
         tu = tu << sh;
         tv = tv << sh;
         none = ~(n1 | n2 | n3);
         tu |= u[0] & none;
         tv |= v[0] & none;
         wa = (u[0] & MASK31) | (tu & MASK_HI33);
         wb = (v[0] & MASK31) | (tv & MASK_HI33);
         fa = 64'd1;
         fb = FB_INIT;
         for (int j = 0; j < 29; j++) begin
            odd = {64{wa[0]}};
            sw = ((wa < wb) ? '1 : '0) & odd;
            acc ^= sw & wa & wb;
            t = sw & (wa ^ wb); wa ^= t; wb ^= t;
            t = sw & (fa ^ fb); fa ^= t; fb ^= t;
            wa -= odd & wb;
            fa -= odd & fb;
            wa = wa >> 1;
            fb = fb << 1;
            t = wb + 64'd2;
            acc ^= t >> 1;
         end
         za = fa + BIAS;
         zb = fb + BIAS;
         f0 = (za & MASK32) - MASK31;
         g0 = (za >> 32) - MASK31;
         f1 = (zb & MASK32) - MASK31;
         g1 = (zb >> 32) - MASK31;
         t = u[0] * f0 + v[0] * g0;
         pa = t >> 29;
         t = u[0] * f1 + v[0] * g1;
         pb = t >> 29;
         for (int j = 0; j < 2; j++) begin
            odd = {64{wa[0]}};
            sw = ((wa < wb) ? '1 : '0) & odd;
            acc ^= sw & pa & pb;
            t = sw & (wa ^ wb); wa ^= t; wb ^= t;
            t = sw & (fa ^ fb); fa ^= t; fb ^= t;
            t = sw & (pa ^ pb); pa ^= t; pb ^= t;
            wa -= odd & wb;
            fa -= odd & fb;
            pa -= odd & pb;
            wa = wa >> 1;
            fb = fb << 1;
            pa = pa >> 1;
            t = pb + 64'd2;
            acc ^= t >> 1;
         end
         fa += BIAS;
         fb += BIAS;
         f0 = (fa & MASK32) - MASK31;
         g0 = (fa >> 32) - MASK31;
         f1 = (fb & MASK32) - MASK31;
         g1 = (fb >> 32) - MASK31;
         neg = scaled_combine(nu, u, v, f0, g0);
         ignored = scaled_combine(nv, u, v, f1, g1);
         acc ^= neg & nv[0];
         u = nu;
         v = nv;
      end
      wa = u[0];
      wb = v[0];
      for (int j = 0; j < 35; j++) begin
         odd = {64{wa[0]}};
         sw = ((wa < wb) ? '1 : '0) & odd;
         acc ^= sw & wa & wb;
         t = sw & (wa ^ wb); wa ^= t; wb ^= t;
         wa -= odd & wb;
         wa = wa >> 1;
         t = wb + 64'd2;
         acc ^= t >> 1;
      end
      return !acc[1] && (value != '0);
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (residue_queue.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            bit expected_square;
            expected_square = residue_queue.pop_front();
            if (rsp_is_square !== expected_square)
               report_mismatch($sformatf("is_square got %b expected %b",
                                         rsp_is_square, expected_square));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_value(input logic [255:0] value);
      int unsigned gap;
      gap = 0;
      if (idle_enable && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 12);
      // start was lowered at the previous acceptance; wait, plus any random gap, before raising it
      repeat (1 + gap) @(posedge clock);
      start <= 1'b1;
      req_value_limb0 <= value[63:0];
      req_value_limb1 <= value[127:64];
      req_value_limb2 <= value[191:128];
      req_value_limb3 <= value[255:192];
      do @(posedge clock); while (busy);
      residue_queue.push_back(predict_residue(value));
      start <= 1'b0;
   endtask

   task automatic wait_drained();
      while (residue_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [255:0] random_value();
      logic [255:0] v;
      v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = v >> $urandom_range(1, 255);
         1: v = MODULUS - v[63:0];
         2: v = MODULUS + v[31:0];
         3: v = v & {8{$urandom}};
         4: v = v | {8{$urandom}};
         default: if (v >= MODULUS) v = v - MODULUS;
      endcase
      return v;
   endfunction

   task automatic test_directed();
      logic [255:0] edge_values[$];
      edge_values = '{256'd0, 256'd1, 256'd2, 256'd3, 256'd4, 256'd9,
                      MODULUS - 1, MODULUS - 4, MODULUS, MODULUS + 1, '1,
                      {192'd0, 64'hFFFF_FFFF_FFFF_FFFF}, {128'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0},
                      {64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 128'd0},
                      {64'hFFFF_FFFF_FFFF_FFFF, 192'd0}, 256'd1 << 255, 256'd1 << 128,
                      {4{64'hAAAA_AAAA_AAAA_AAAA}}, {4{64'h5555_5555_5555_5555}},
                      MODULUS >> 1, 256'h7FFF_FFFF};
      foreach (edge_values[i]) send_value(edge_values[i]);
   endtask

   task automatic test_random(input int unsigned count);
      repeat (count) send_value(random_value());
   endtask

   task automatic test_drained_start();
      wait_drained();
      send_value(random_value());
      wait_drained();
      send_value(256'd16);
   endtask

   task automatic test_back_to_back(input int unsigned count);
      idle_enable = 1'b0;
      repeat (count) send_value(random_value());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(540);
      test_drained_start();
      test_back_to_back(40);
      while (residue_queue.size() != 0) @(posedge clock);
      repeat (LATENCY / 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
